// ----- sv/mh2_pkg.sv -----
// Shared types, constants and helper functions for the streaming MurmurHash2 block.
// No dependencies; every other file in this folder imports it.
package mh2_pkg;

    localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
    localparam int          SHIFT_K    = 24;
    localparam int          SHIFT_A1   = 13;
    localparam int          SHIFT_A2   = 15;
    localparam int          FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_SEED    = 1'b0;
    localparam cfg_index_t REG_SKIP_WS = 1'b1;

    // One command from the front end to the mixing engine.
    typedef struct packed {
        logic        load;     // start of message: load accumulator from init
        logic        mix;      // mix a full little-endian word
        logic        fin;      // finalize and emit the hash
        logic        tail;     // fold in leftover tail bytes before finalizing
        logic [31:0] init;     // seed XOR length
        logic [31:0] data;     // full word when mix, else tail bytes
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_K1,
        BK_K2,
        BK_HMIX,
        BK_TAIL,
        BK_AVAL
    } bk_state_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_SPACE);
    endfunction

endpackage

// ----- sv/mh2_fifo.sv -----
// Small register queue of mixing commands between the front end and the engine.
// Depends on mh2_pkg for the command type.
module mh2_fifo import mh2_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/mh2_front.sv -----
// Front end: holds the configuration, filters whitespace, tracks message state,
// packs bytes into words and issues mixing commands. Depends on mh2_pkg.
module mh2_front import mh2_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  cfg_index_t  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic [31:0] message_length,
    input  logic        last_item,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic [31:0] seed_reg;
    logic        skip_reg;
    logic        in_msg_reg, in_msg_next;
    logic        pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [23:0] pw_reg, pw_next;
    logic [31:0] init_reg, init_next;

    logic        accept, kept, starting, pend, mix;
    logic [1:0]  cnt;
    logic [23:0] pw;

    assign item_ready = cmd_ready;
    assign accept     = item_valid && item_ready;

    always_comb begin
        kept     = byte_valid && !(skip_reg && is_blank(data_byte));
        starting = !in_msg_reg && (kept || last_item);
        pend     = starting || pend_reg;
        cnt      = starting ? 2'd0 : cnt_reg;
        pw       = starting ? 24'd0 : pw_reg;
        init_next = starting ? (seed_reg ^ message_length) : init_reg;
        mix      = 1'b0;
        cnt_next = cnt;
        pw_next  = pw;

        if (kept) begin
            if (cnt == 2'd3) begin
                mix      = 1'b1;
                cnt_next = 2'd0;
                pw_next  = '0;
            end else begin
                pw_next  = pw | (24'(data_byte) << {cnt, 3'b000});
                cnt_next = cnt + 2'd1;
            end
        end

        cmd.load = pend;
        cmd.mix  = mix;
        cmd.fin  = last_item;
        cmd.tail = last_item && (cnt_next != 2'd0);
        cmd.init = init_next;
        cmd.data = mix ? {data_byte, pw} : {8'd0, pw_next};
        cmd_valid = item_valid && (mix || last_item);

        // The load flag rides on the first command of each message.
        pend_next   = (mix || last_item) ? 1'b0 : pend;
        in_msg_next = (starting || in_msg_reg) && !last_item;
        if (last_item) begin
            cnt_next = 2'd0;
            pw_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= '0;
            skip_reg   <= 1'b0;
            in_msg_reg <= 1'b0;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SEED:    seed_reg <= cfg_wdata;
                    REG_SKIP_WS: skip_reg <= cfg_wdata[0];
                    default:     ;
                endcase
            end
            if (accept) begin
                in_msg_reg <= in_msg_next;
                pend_reg   <= pend_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pw_reg   <= pw_next;
            init_reg <= init_next;
        end
    end

endmodule

// ----- sv/mh2_back.sv -----
// Mixing engine: executes queued commands on one shared multiply-by-constant
// unit and holds the finished hash in an output register. Depends on mh2_pkg.
module mh2_back import mh2_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_hash
);

    bk_state_t   state_reg, state_next;
    cmd_t        cmd_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] hash_reg, hash_next;
    logic        valid_reg, valid_next;
    logic [31:0] mul_in, prod;
    logic        out_free, take_cmd;

    assign out_free  = !valid_reg || out_ready;
    assign prod      = mul_in * MIX_MUL;
    assign cmd_ready = (state_reg == BK_IDLE);
    assign take_cmd  = cmd_valid && cmd_ready;
    assign out_valid = valid_reg;
    assign out_hash  = hash_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.mix) begin
                        state_next = BK_K1;
                    end else if (cmd.tail) begin
                        state_next = BK_TAIL;
                    end else begin
                        state_next = BK_AVAL;
                    end
                end
            end
            BK_K1:   state_next = BK_K2;
            BK_K2:   state_next = BK_HMIX;
            BK_HMIX: state_next = cmd_reg.fin ? BK_AVAL : BK_IDLE;
            BK_TAIL: state_next = BK_AVAL;
            BK_AVAL: state_next = out_free ? BK_IDLE : BK_AVAL;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        mul_in     = h_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        hash_next  = hash_reg;
        valid_next = valid_reg && !out_ready;
        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && cmd.load) begin
                    h_next = cmd.init;
                end
            end
            BK_K1: begin
                mul_in = cmd_reg.data;
                k_next = prod;
            end
            BK_K2: begin
                mul_in = k_reg ^ (k_reg >> SHIFT_K);
                k_next = prod;
            end
            BK_HMIX: begin
                mul_in = h_reg;
                h_next = prod ^ k_reg;
            end
            BK_TAIL: begin
                mul_in = h_reg ^ cmd_reg.data;
                h_next = prod;
            end
            BK_AVAL: begin
                mul_in = h_reg ^ (h_reg >> SHIFT_A1);
                if (out_free) begin
                    hash_next  = prod ^ (prod >> SHIFT_A2);
                    valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_cmd) begin
            cmd_reg <= cmd;
        end
        h_reg    <= h_next;
        k_reg    <= k_next;
        hash_reg <= hash_next;
    end

endmodule

// ----- sv/murmur2_hash32_stream.sv -----
// Top level of the streaming 32-bit MurmurHash2 block.
// Instantiates mh2_front, mh2_fifo and mh2_back; depends on mh2_pkg.
//
// The block takes one message byte per transfer and returns the 32-bit hash in
// one result transfer after the transfer that carries tlast. The front end
// accepts a byte every cycle while its command queue has room. The engine runs
// every multiplication through one 32x32 multiply-by-constant unit, so a full
// four-byte word takes a queue pop and three multiplies (K1, K2, HMIX), which
// sustains one byte per cycle while no hash is held up. A message end takes a
// pop, the word mix or a tail multiply where there is one, then the avalanche
// (held while the last hash is unread) before the hash shows on m_tvalid.
// Configuration writes take effect at once; seed is sampled at the first kept
// byte of a message, or at an end mark that arrives while idle.
module murmur2_hash32_stream import mh2_pkg::*; #(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  cfg_index_t  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], message_length [39:8]
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hash_value [31:0]
);

    logic cmd_valid, cmd_ready, q_valid, q_ready;
    cmd_t cmd, q_cmd;

    mh2_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .item_valid     (s_tvalid),
        .item_ready     (s_tready),
        .data_byte      (s_tdata[7:0]),
        .byte_valid     (s_tuser),
        .message_length (s_tdata[39:8]),
        .last_item      (s_tlast),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    mh2_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_cmd   (cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    mh2_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hash  (m_tdata)
    );

endmodule

// ----- sim/tb_murmur2_hash32_stream.sv -----
// Self-checking testbench for murmur2_hash32_stream: byte streams in, 32-bit hashes out.
// Depends on mh2_pkg and the block's RTL; a class tracks the hash state and checks results.
module tb_murmur2_hash32_stream import mh2_pkg::*; ;

    localparam logic [31:0] MURMUR_M       = 32'h5bd1e995;
    localparam logic [7:0]  BYTE_TAB       = 8'h09;
    localparam logic [7:0]  BYTE_LF        = 8'h0a;
    localparam logic [7:0]  BYTE_CR        = 8'h0d;
    localparam logic [7:0]  BYTE_SPACE     = 8'h20;
    localparam int          RANDOM_ITEMS   = 1700;
    localparam int          PHASE_ITEMS    = 180;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          HOLDOFF_CYCLES = 400;
    localparam int          WATCHDOG_LIMIT = 3000;

    // Tracks the hash state byte by byte and keeps the hashes still owed by the block.
    class hash_tracker;
        logic [31:0] seed_reg;
        bit          skip_blanks;
        logic [31:0] acc;
        logic [23:0] tail_bytes;
        int unsigned tail_count;
        bit          in_msg;
        logic [31:0] expected_hashes[$];
        int unsigned errors;
        int unsigned bytes_noted;
        int unsigned hashes_checked;

        function new();
            seed_reg = '0;
            skip_blanks = 1'b0;
            acc = '0;
            tail_bytes = '0;
            tail_count = 0;
            in_msg = 1'b0;
            errors = 0;
            bytes_noted = 0;
            hashes_checked = 0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR || b == BYTE_SPACE;
        endfunction

        function void set_config(logic [31:0] seed, bit skip);
            seed_reg = seed;
            skip_blanks = skip;
        endfunction

        function int pending();
            return expected_hashes.size();
        endfunction

        function void note_byte(logic [7:0] b, bit valid, logic [31:0] len, bit last);
            logic [31:0] k;
            logic [31:0] h;
            bit          kept;
            kept = valid && !(skip_blanks && is_blank(b));
            bytes_noted++;
            // The accumulator is loaded at the first kept byte, or at an end mark while idle.
            if (!in_msg && (kept || last)) begin
                acc = seed_reg ^ len;
                tail_bytes = '0;
                tail_count = 0;
                in_msg = 1'b1;
            end
            if (kept) begin
                if (tail_count == 3) begin
                    k = {b, tail_bytes};
                    k = k * MURMUR_M;
                    k = k ^ (k >> 24);
                    k = k * MURMUR_M;
                    acc = (acc * MURMUR_M) ^ k;
                    tail_bytes = '0;
                    tail_count = 0;
                end else begin
                    tail_bytes[8*tail_count +: 8] = b;
                    tail_count++;
                end
            end
            if (last) begin
                h = acc;
                if (tail_count != 0) begin
                    h = h ^ {8'h00, tail_bytes};
                    h = h * MURMUR_M;
                end
                h = h ^ (h >> 13);
                h = h * MURMUR_M;
                h = h ^ (h >> 15);
                expected_hashes.push_back(h);
                acc = h;
                tail_bytes = '0;
                tail_count = 0;
                in_msg = 1'b0;
            end
        endfunction

        function void check_hash(logic [31:0] actual);
            logic [31:0] want;
            if (expected_hashes.size() == 0) begin
                $display("%0t: hash %08h arrived with none expected", $time, actual);
                errors++;
                return;
            end
            want = expected_hashes.pop_front();
            hashes_checked++;
            if (actual !== want) begin
                $display("%0t: hash mismatch, expected %08h, actual %08h", $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_index = REG_SEED;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // data_byte [7:0], message_length [39:8]
    logic        s_tuser   = 1'b0; // byte_valid
    logic        s_tlast   = 1'b0; // last_item
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // hash_value [31:0]

    hash_tracker sb = new();

    int unsigned items_sent    = 0;
    int unsigned burst_left    = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles  = 0;
    bit          steady_sender = 1'b0;
    bit          holdoff_req   = 1'b0;

    murmur2_hash32_stream i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_byte(s_tdata[7:0], s_tuser, s_tdata[39:8], s_tlast);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_hash(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: a 16-bit ready mask, replayed four times over before it is redrawn,
    // with a long hold-off on request.
    initial begin : result_sink
        logic [15:0] mask;
        int unsigned slot;
        mask = '1;
        slot = 0;
        forever begin
            @(posedge aclk);
            if (holdoff_req) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_req = 1'b0;
            end
            if (slot == 0) begin
                case ($urandom_range(0, 3))
                    0: mask = '1;
                    1: mask = 16'($urandom());
                    2: mask = 16'($urandom()) | 16'($urandom());
                    default: mask = 16'($urandom()) & 16'($urandom()) & 16'($urandom());
                endcase
            end
            m_tready <= mask[slot[3:0]];
            slot = (slot + 1) % 64;
        end
    end

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0: return BYTE_TAB;
            1: return BYTE_LF;
            2: return BYTE_CR;
            default: return BYTE_SPACE;
        endcase
    endfunction

    // Offers one item and returns at the edge where it is taken. s_tvalid stays high so
    // that a following item goes out back to back unless a gap is drawn.
    task automatic send_item(input logic [7:0] b, input bit valid, input logic [31:0] len,
                             input bit last);
        int unsigned gap;
        if (!steady_sender) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 7);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, b};
        s_tuser  <= valid;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Waits until every owed hash has come back, then lets the engine settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [31:0] seed, input bit skip);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SEED;
        cfg_wdata <= seed;
        @(posedge aclk);
        cfg_index <= REG_SKIP_WS;
        cfg_wdata <= {31'b0, skip};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_config(seed, skip);
        settings_used++;
    endtask

    task automatic send_random_message();
        int unsigned n;
        int unsigned kept;
        logic [31:0] len;
        logic [7:0]  msg_bytes[$];
        bit          msg_valid[$];
        logic [7:0]  b;
        bit          v;
        bit          end_apart;
        // Now and then some ignored items go out while the block is idle.
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                if (sb.skip_blanks) begin
                    send_item(blank_byte(), 1'($urandom_range(0, 1)), $urandom(), 1'b0);
                end else begin
                    send_item(8'($urandom()), 1'b0, $urandom(), 1'b0);
                end
            end
        end
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        kept = 0;
        for (int i = 0; i < n; i++) begin
            b = ($urandom_range(0, 3) == 0) ? blank_byte() : 8'($urandom());
            v = ($urandom_range(0, 9) != 0);
            if (v && !(sb.skip_blanks && sb.is_blank(b))) kept++;
            msg_bytes.push_back(b);
            msg_valid.push_back(v);
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom() : kept;
        end_apart = (n == 0) || ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++) begin
            send_item(msg_bytes[i], msg_valid[i], len, !end_apart && (i == n - 1));
        end
        if (end_apart) send_item(8'($urandom()), 1'b0, len, 1'b1);
    endtask

    initial begin : stimulus
        int unsigned target;
        int unsigned phase_end;
        int unsigned phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_config(32'hffff_ffff, 1'b0);
        // One full word and no tail bytes.
        send_item(8'h00, 1'b1, 32'd4, 1'b0);
        send_item(8'hff, 1'b1, 32'd4, 1'b0);
        send_item(8'h80, 1'b1, 32'd4, 1'b0);
        send_item(8'h7f, 1'b1, 32'd4, 1'b1);
        // Empty message: end mark with no byte while idle.
        send_item(8'hff, 1'b0, 32'hffff_ffff, 1'b1);
        // An invalid byte while idle is ignored; one more mid-message.
        send_item(8'h5a, 1'b0, 32'h1234_5678, 1'b0);
        send_item(8'h01, 1'b1, 32'd3, 1'b0);
        send_item(8'h02, 1'b1, 32'd3, 1'b0);
        send_item(8'h03, 1'b0, 32'd3, 1'b0);
        send_item(8'hfe, 1'b1, 32'd3, 1'b1);
        // The given length disagrees with the five bytes sent.
        send_item(8'h11, 1'b1, 32'd0, 1'b0);
        send_item(8'h22, 1'b1, 32'd0, 1'b0);
        send_item(8'h33, 1'b1, 32'd0, 1'b0);
        send_item(8'h44, 1'b1, 32'd0, 1'b0);
        send_item(8'h55, 1'b1, 32'd0, 1'b1);
        drain_results();

        write_config(32'h0000_0000, 1'b1);
        // A dropped blank while idle must not sample its length.
        send_item(BYTE_SPACE, 1'b1, 32'hdead_beef, 1'b0);
        send_item(8'h61, 1'b1, 32'd2, 1'b0);
        send_item(BYTE_TAB, 1'b1, 32'd2, 1'b0);
        send_item(BYTE_LF, 1'b1, 32'd2, 1'b0);
        send_item(8'h62, 1'b1, 32'd2, 1'b0);
        send_item(BYTE_CR, 1'b1, 32'd2, 1'b0);
        send_item(BYTE_SPACE, 1'b1, 32'd2, 1'b1);
        send_item(BYTE_LF, 1'b1, 32'd7, 1'b1);
        // Turning blank skipping off in the middle of a message.
        send_item(8'h41, 1'b1, 32'd3, 1'b0);
        send_item(8'h42, 1'b1, 32'd3, 1'b0);
        drain_results();
        write_config(32'h8000_0001, 1'b0);
        send_item(BYTE_SPACE, 1'b1, 32'd3, 1'b1);

        target = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < target) begin
            drain_results();
            case (phase % 5)
                0: write_config(32'h0000_0000, 1'b0);
                1: write_config(32'hffff_ffff, 1'b1);
                2: write_config($urandom(), 1'b0);
                3: write_config($urandom(), 1'b1);
                default: write_config($urandom(), 1'($urandom_range(0, 1)));
            endcase
            steady_sender = (phase % 4 == 1);
            if (phase == 3) begin
                // Results back up behind a stalled receiver until the input stalls too.
                holdoff_req = 1'b1;
                repeat (40) send_item(8'($urandom()), 1'b1, 32'd1, 1'b1);
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < target) send_random_message();
            phase++;
        end
        drain_results();

        $display("Run covered %0d input transfers and %0d hash results over %0d register settings,",
                 sb.bytes_noted, sb.hashes_checked, settings_used);
        $display("with blank skipping on and off and a long stall on the result side.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
